>>> rtl/ttbd_pkg.sv
// Package: shared types and codes for the tick timers with button debounce block.
package ttbd_pkg;

    // Input item operation codes
    typedef enum logic [1:0] {
        MODE_TICK      = 2'd0,
        MODE_START_LED = 2'd1,
        MODE_FIRE_FLSH = 2'd2,
        MODE_SET_OFF   = 2'd3
    } t_mode;

    // Configuration register indexes
    localparam logic [7:0] CFG_FLASH_PULSE_TICKS = 8'd0;
    localparam logic [7:0] CFG_SETTLE_COUNT      = 8'd1;

    // Configuration reset values
    localparam logic [7:0] FLASH_PULSE_RESET = 8'd6;
    localparam logic [7:0] SETTLE_RESET      = 8'd5;

    // One input item
    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] value;
        logic        button_level;
    } t_in_item;

    // One result item
    typedef struct packed {
        logic        led_on;
        logic        flash_out;
        logic [31:0] off_remaining;
        logic        button_stable;
        logic [15:0] button_duration;
    } t_out_item;

endpackage

>>> rtl/tick_timers_with_button_debounce.sv
// Top level: LED and flash one-shot timers, off-interval countdown and button debouncer.
//
// Each accepted transaction is a tick or a command, applied to the timer and
// debounce state in the cycle it is accepted; its result lands in the output
// register on the same edge. One transaction is taken every cycle unless the
// output stalls: the input is ready whenever the output register is empty or
// is being drained, so the sustained rate is one item per clock. The button
// is sampled on every SAMPLE_PERIOD-th tick, starting with the first tick
// after reset. Configuration writes are always ready and take effect on the
// next transaction; writes to unknown indexes are dropped.
module tick_timers_with_button_debounce
    import ttbd_pkg::*;
#(
    parameter int SAMPLE_PERIOD = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out_data,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    localparam int PHASE_W = (SAMPLE_PERIOD > 1) ? $clog2(SAMPLE_PERIOD) : 1;
    localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(SAMPLE_PERIOD - 1);
    localparam logic [15:0] DUR_STEP = 16'(SAMPLE_PERIOD);

    // Configuration registers
    logic [7:0] r_flash_pulse_ticks;
    logic [7:0] r_settle_count;

    // Timer and debounce state
    logic [15:0]        r_led_count,      n_led_count;
    logic               r_led_drive,      n_led_drive;
    logic [7:0]         r_flash_count,    n_flash_count;
    logic               r_flash_drive,    n_flash_drive;
    logic [31:0]        r_off_count,      n_off_count;
    logic [PHASE_W-1:0] r_tick_phase,     n_tick_phase;
    logic               r_prev_sample,    n_prev_sample;
    logic [7:0]         r_settle_left,    n_settle_left;
    logic               r_stable_level,   n_stable_level;
    logic [15:0]        r_level_duration, n_level_duration;

    // Output register
    logic      r_out_valid;
    t_out_item r_out_data;

    logic  in_fire;
    t_mode mode;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign mode        = t_mode'(i_in_data.mode);

    // Take configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flash_pulse_ticks <= FLASH_PULSE_RESET;
            r_settle_count      <= SETTLE_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_FLASH_PULSE_TICKS) begin
                r_flash_pulse_ticks <= i_cfg_data;
            end else if (i_cfg_index == CFG_SETTLE_COUNT) begin
                r_settle_count <= i_cfg_data;
            end
        end
    end

    // Compute next state for the incoming transaction
    always_comb begin
        n_led_count      = r_led_count;
        n_led_drive      = r_led_drive;
        n_flash_count    = r_flash_count;
        n_flash_drive    = r_flash_drive;
        n_off_count      = r_off_count;
        n_tick_phase     = r_tick_phase;
        n_prev_sample    = r_prev_sample;
        n_settle_left    = r_settle_left;
        n_stable_level   = r_stable_level;
        n_level_duration = r_level_duration;
        case (mode)
            MODE_TICK: begin
                // Count the one-shots down; drop the drive on reaching zero
                if (r_led_count != 16'd0) begin
                    n_led_count = r_led_count - 16'd1;
                    if (r_led_count == 16'd1) begin
                        n_led_drive = 1'b0;
                    end
                end
                if (r_flash_count != 8'd0) begin
                    n_flash_count = r_flash_count - 8'd1;
                    if (r_flash_count == 8'd1) begin
                        n_flash_drive = 1'b0;
                    end
                end
                if (r_off_count != 32'd0) begin
                    n_off_count = r_off_count - 32'd1;
                end
                // Sample the button at phase zero
                if (r_tick_phase == '0) begin
                    if (i_in_data.button_level != r_prev_sample) begin
                        n_settle_left    = r_settle_count;
                        n_level_duration = 16'd0;
                    end else if (r_settle_left == 8'd0) begin
                        n_stable_level   = i_in_data.button_level;
                        n_level_duration = r_level_duration + DUR_STEP;
                    end else begin
                        n_settle_left = r_settle_left - 8'd1;
                    end
                    n_prev_sample = i_in_data.button_level;
                end
                // Advance the sample phase
                if (r_tick_phase == PHASE_LAST) begin
                    n_tick_phase = '0;
                end else begin
                    n_tick_phase = r_tick_phase + PHASE_W'(1);
                end
            end
            MODE_START_LED: begin
                n_led_count = i_in_data.value[15:0];
                n_led_drive = 1'b1;
            end
            MODE_FIRE_FLSH: begin
                n_flash_count = r_flash_pulse_ticks;
                n_flash_drive = 1'b1;
            end
            MODE_SET_OFF: begin
                n_off_count = i_in_data.value;
            end
            default: begin
                n_off_count = r_off_count;
            end
        endcase
    end

    // Update state and output register on an accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_count      <= 16'd0;
            r_led_drive      <= 1'b0;
            r_flash_count    <= 8'd0;
            r_flash_drive    <= 1'b0;
            r_off_count      <= 32'd0;
            r_tick_phase     <= '0;
            r_prev_sample    <= 1'b0;
            r_settle_left    <= 8'd0;
            r_stable_level   <= 1'b1;
            r_level_duration <= 16'd0;
            r_out_valid      <= 1'b0;
        end else begin
            if (in_fire) begin
                r_led_count      <= n_led_count;
                r_led_drive      <= n_led_drive;
                r_flash_count    <= n_flash_count;
                r_flash_drive    <= n_flash_drive;
                r_off_count      <= n_off_count;
                r_tick_phase     <= n_tick_phase;
                r_prev_sample    <= n_prev_sample;
                r_settle_left    <= n_settle_left;
                r_stable_level   <= n_stable_level;
                r_level_duration <= n_level_duration;
                r_out_valid      <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the result payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out_data.led_on          <= n_led_drive;
            r_out_data.flash_out       <= n_flash_drive;
            r_out_data.off_remaining   <= n_off_count;
            r_out_data.button_stable   <= n_stable_level;
            r_out_data.button_duration <= n_level_duration;
        end
    end

    // An LED timer with its drive off never holds a running count
    a_led_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_led_drive |-> (r_led_count == 16'd0))
        else $error("LED count running with drive off");

    // An idle flash timer never leaves a count behind
    a_flash_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_flash_drive |-> (r_flash_count == 8'd0))
        else $error("flash count running with drive off");

    // An accepted transaction always produces a result next cycle
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_out_valid && (r_out_data.off_remaining == r_off_count)))
        else $error("accepted transaction produced no matching result");

endmodule
